@@ design/tlfo_pkg.sv @@
package tlfo_pkg;

  // Sample width of every audio field on the ports.
  localparam int SAMPLE_BITS = 24;
  localparam int S_MAX = (2 ** (SAMPLE_BITS - 1)) - 1;
  localparam int S_MIN = -(2 ** (SAMPLE_BITS - 1));

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN       = 3'd0,
    REG_DEPTH      = 3'd1,
    REG_WAVE_SHAPE = 3'd2,
    REG_PHASE_STEP = 3'd3,
    REG_FOUR_CH    = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SHAPE_SINE     = 2'd0,
    SHAPE_TRIANGLE = 2'd1,
    SHAPE_SQUARE   = 2'd2,
    SHAPE_SLOPED   = 2'd3
  } shape_e;

  localparam logic [15:0] GAIN_RESET  = 16'd5161;
  localparam logic [15:0] DEPTH_RESET = 16'd32768;
  localparam shape_e      SHAPE_RESET = SHAPE_SQUARE;
  localparam logic [31:0] STEP_RESET  = 32'd178957;

  // Edges of the sloped square wave, as fractions of a full turn in 32 bits.
  localparam logic [31:0] EDGE_FALL = 32'd2061584302;
  localparam logic [31:0] EDGE_RISE = 32'd4209067950;
  localparam int          SLOPE_MUL = 50;

  // Odd sine polynomial in Q30, evaluated by Horner steps from the top.
  localparam logic [31:0] POLY_SEED = 32'd172272;
  localparam logic [31:0] POLY_COEF [4] = '{
    32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };
  localparam logic [1:0] POLY_LAST = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] front_left;
    logic signed [SAMPLE_BITS-1:0] front_right;
    logic signed [SAMPLE_BITS-1:0] side_left;
    logic signed [SAMPLE_BITS-1:0] side_right;
    logic                          side_valid;
  } out_word_t;

  // Microcode: operand selects of the shared multiplier, the register that
  // takes the previous product, and the branch of the step.
  typedef enum logic [3:0] {
    A_NONE, A_XL, A_XR, A_FRAC, A_SLOPE, A_K, A_T, A_X, A_P, A_DEPTH, A_FL, A_FR
  } op_a_e;

  typedef enum logic [3:0] {
    B_NONE, B_GAIN, B_SIZE, B_FIFTY, B_REM, B_QUOT, B_RECIP, B_X, B_X2, B_LFO, B_MOD
  } op_b_e;

  typedef enum logic [3:0] {
    W_NONE, W_FL, W_FR, W_K, W_T, W_X, W_XADD, W_X2, W_POLY, W_SINE, W_SHAPE,
    W_M, W_SL, W_SR
  } wr_e;

  typedef enum logic [2:0] {
    J_NEXT, J_ALWAYS, J_TWO_CH, J_NOT_SINE, J_LOOP, J_HOLD
  } jmp_e;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] U_GAIN_L = 5'd0;
  localparam logic [PC_W-1:0] U_GAIN_R = 5'd1;
  localparam logic [PC_W-1:0] U_INDEX  = 5'd2;
  localparam logic [PC_W-1:0] U_MIRROR = 5'd3;
  localparam logic [PC_W-1:0] U_REM    = 5'd4;
  localparam logic [PC_W-1:0] U_QUOT   = 5'd5;
  localparam logic [PC_W-1:0] U_RECIP  = 5'd6;
  localparam logic [PC_W-1:0] U_XSUM   = 5'd7;
  localparam logic [PC_W-1:0] U_SQUARE = 5'd8;
  localparam logic [PC_W-1:0] U_X2     = 5'd9;
  localparam logic [PC_W-1:0] U_HORNER = 5'd10;
  localparam logic [PC_W-1:0] U_COEF   = 5'd11;
  localparam logic [PC_W-1:0] U_ODD    = 5'd12;
  localparam logic [PC_W-1:0] U_SINE   = 5'd13;
  localparam logic [PC_W-1:0] U_SHAPE  = 5'd14;
  localparam logic [PC_W-1:0] U_DEPTH  = 5'd15;
  localparam logic [PC_W-1:0] U_MOD    = 5'd16;
  localparam logic [PC_W-1:0] U_SIDE_L = 5'd17;
  localparam logic [PC_W-1:0] U_SIDE_R = 5'd18;
  localparam logic [PC_W-1:0] U_SR     = 5'd19;
  localparam logic [PC_W-1:0] U_DONE   = 5'd20;

  typedef struct packed {
    op_a_e             a;
    op_b_e             b;
    wr_e               wr;
    jmp_e              jmp;
    logic [PC_W-1:0]   target;
  } ucode_t;

  function automatic ucode_t ucode_at(input logic [PC_W-1:0] pc);
    ucode_t uc;
    case (pc)
      U_GAIN_L: uc = '{A_XL,    B_GAIN,  W_NONE,  J_NEXT,     U_DONE};
      U_GAIN_R: uc = '{A_XR,    B_GAIN,  W_FL,    J_NEXT,     U_DONE};
      U_INDEX:  uc = '{A_FRAC,  B_SIZE,  W_FR,    J_TWO_CH,   U_DONE};
      U_MIRROR: uc = '{A_SLOPE, B_FIFTY, W_K,     J_NOT_SINE, U_SHAPE};
      U_REM:    uc = '{A_K,     B_REM,   W_NONE,  J_NEXT,     U_DONE};
      U_QUOT:   uc = '{A_K,     B_QUOT,  W_T,     J_NEXT,     U_DONE};
      U_RECIP:  uc = '{A_T,     B_RECIP, W_X,     J_NEXT,     U_DONE};
      U_XSUM:   uc = '{A_NONE,  B_NONE,  W_XADD,  J_NEXT,     U_DONE};
      U_SQUARE: uc = '{A_X,     B_X,     W_NONE,  J_NEXT,     U_DONE};
      U_X2:     uc = '{A_NONE,  B_NONE,  W_X2,    J_NEXT,     U_DONE};
      U_HORNER: uc = '{A_P,     B_X2,    W_NONE,  J_NEXT,     U_DONE};
      U_COEF:   uc = '{A_NONE,  B_NONE,  W_POLY,  J_LOOP,     U_HORNER};
      U_ODD:    uc = '{A_P,     B_X,     W_NONE,  J_NEXT,     U_DONE};
      U_SINE:   uc = '{A_NONE,  B_NONE,  W_SINE,  J_ALWAYS,   U_DEPTH};
      U_SHAPE:  uc = '{A_NONE,  B_NONE,  W_SHAPE, J_NEXT,     U_DONE};
      U_DEPTH:  uc = '{A_DEPTH, B_LFO,   W_NONE,  J_NEXT,     U_DONE};
      U_MOD:    uc = '{A_NONE,  B_NONE,  W_M,     J_NEXT,     U_DONE};
      U_SIDE_L: uc = '{A_FL,    B_MOD,   W_NONE,  J_NEXT,     U_DONE};
      U_SIDE_R: uc = '{A_FR,    B_MOD,   W_SL,    J_NEXT,     U_DONE};
      U_SR:     uc = '{A_NONE,  B_NONE,  W_SR,    J_NEXT,     U_DONE};
      U_DONE:   uc = '{A_NONE,  B_NONE,  W_NONE,  J_HOLD,     U_DONE};
      default:  uc = '{A_NONE,  B_NONE,  W_NONE,  J_HOLD,     U_DONE};
    endcase
    return uc;
  endfunction

endpackage

@@ design/tremolo_lfo_gain_stage.sv @@
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
// frame     in         in_valid_i / in_stall_o   in_data_i (left, right sample)
// result    out        out_valid_o / out_stall_i out_data_o (front, side, side_valid)
//
// In two-channel mode a frame runs only the gain steps; in four-channel mode the
// sine shape adds the polynomial steps that the other shapes skip. The
// microcode runs every product through one shared 33 x 33 multiplier and
// computes the sine entry from its polynomial at run time, so no table is stored.
// Reset is asynchronous, sets the configuration to its reset values and clears the LFO phase and control.
// A word is taken when idle; the last step waits while the output is stalled.
module tremolo_lfo_gain_stage #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tlfo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tlfo_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tlfo_pkg::in_word_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tlfo_pkg::out_word_t                out_data_o
);
  import tlfo_pkg::*;

  // The sine index k runs from 0 to SINE_TABLE_DEPTH inclusive. The angle
  // x = floor(k * 2^30 / D) is built as k * QC + floor(k * RC / D), and the
  // last quotient uses a reciprocal that is exact for k * RC below 2^24.
  localparam int                 KW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam longint unsigned    QC    = 64'h4000_0000 / SINE_TABLE_DEPTH;
  localparam longint unsigned    RC    = 64'h4000_0000 % SINE_TABLE_DEPTH;
  localparam longint unsigned    RECIP = (64'd1 << 37) / SINE_TABLE_DEPTH + 64'd1;

  // Configuration registers.
  logic [15:0]           gain_q;
  logic [15:0]           depth_q;
  shape_e                shape_q;
  logic [PHASE_BITS-1:0] step_q;
  logic                  four_ch_q;

  // Sequencer and output control.
  logic [PC_W-1:0]       pc_q, pc_d;
  logic                  busy_q;
  logic [1:0]            cnt_q;
  logic                  out_valid_q;
  out_word_t             out_q;
  logic [PHASE_BITS-1:0] phase_q;

  // Datapath registers.
  logic signed [SAMPLE_BITS-1:0] xl_q, xr_q, fl_q, fr_q, sl_q, sr_q;
  logic [KW-1:0]                 k_q;
  logic [31:0]                   t_q;
  logic [30:0]                   x_q, x2_q;
  logic [31:0]                   p_q;
  logic [15:0]                   lfo_q;
  logic signed [31:0]            m_q;
  logic signed [65:0]            prod_q, prod_d;

  ucode_t                uc;
  logic                  accept;
  logic                  done;
  logic                  take_jump;
  logic [31:0]           p32;
  logic [31:0]           slope_diff;
  logic signed [32:0]    op_a, op_b;
  logic [KW-1:0]         idx;
  logic [31:0]           s_sum;
  logic [16:0]           s_rnd;
  logic [15:0]           s_cap;
  logic [16:0]           sine_hi, sine_lo;
  logic [15:0]           sine_lfo;
  logic [15:0]           shape_lfo;
  logic [15:0]           u;
  logic [16:0]           slope_d;

  // Round half up at bit sh, then clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(
    input logic signed [65:0] v,
    input int                 sh
  );
    logic signed [66:0] sum;
    logic signed [66:0] q;
    sum = 67'(v) + (67'sd1 <<< (sh - 1));
    q   = sum >>> sh;
    if (q > 67'(S_MAX)) begin
      return SAMPLE_BITS'(S_MAX);
    end else if (q < 67'(S_MIN)) begin
      return SAMPLE_BITS'(S_MIN);
    end
    return SAMPLE_BITS'(q);
  endfunction

  assign uc     = ucode_at(pc_q);
  assign accept = in_valid_i && !busy_q;
  assign done   = busy_q && (uc.jmp == J_HOLD) && (!out_valid_q || !out_stall_i);

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The phase as a 32-bit fraction of a turn.
  assign p32        = 32'(phase_q) << (32 - PHASE_BITS);
  assign slope_diff = p32[31] ? (p32 - EDGE_RISE) : (p32 - EDGE_FALL);

  // Shared multiplier operands.
  always_comb begin
    case (uc.a)
      A_XL:    op_a = 33'(xl_q);
      A_XR:    op_a = 33'(xr_q);
      A_FRAC:  op_a = {3'b000, p32[29:0]};
      A_SLOPE: op_a = {1'b0, slope_diff};
      A_K:     op_a = 33'(k_q);
      A_T:     op_a = {1'b0, t_q};
      A_X:     op_a = {2'b00, x_q};
      A_P:     op_a = {1'b0, p_q};
      A_DEPTH: op_a = {17'd0, depth_q};
      A_FL:    op_a = 33'(fl_q);
      A_FR:    op_a = 33'(fr_q);
      default: op_a = '0;
    endcase
  end

  always_comb begin
    case (uc.b)
      B_GAIN:  op_b = {17'd0, gain_q};
      B_SIZE:  op_b = 33'(SINE_TABLE_DEPTH);
      B_FIFTY: op_b = 33'(SLOPE_MUL);
      B_REM:   op_b = 33'(RC);
      B_QUOT:  op_b = 33'(QC);
      B_RECIP: op_b = 33'(RECIP);
      B_X:     op_b = {2'b00, x_q};
      B_X2:    op_b = {2'b00, x2_q};
      B_LFO:   op_b = {17'd0, lfo_q};
      B_MOD:   op_b = 33'(m_q);
      default: op_b = '0;
    endcase
  end

  assign prod_d = op_a * op_b;

  // Quarter-wave index; odd quadrants use the index mirrored.
  assign idx = prod_q[30 +: KW];

  // Sine entry from the polynomial product, rounded to Q1.15 and capped.
  assign s_sum    = prod_q[61:30] + 32'd16384;
  assign s_rnd    = s_sum[31:15];
  assign s_cap    = (s_rnd > 17'd32768) ? 16'd32768 : s_rnd[15:0];
  assign sine_hi  = 17'd32768 + {1'b0, s_cap};
  assign sine_lo  = 17'd32768 - {1'b0, s_cap};
  assign sine_lfo = p32[31] ? sine_lo[16:1] : sine_hi[16:1];

  // Triangle, square and sloped square, the last from the slope product.
  assign u       = p32[31:16];
  assign slope_d = prod_q[33:17];

  always_comb begin
    case (shape_q)
      SHAPE_TRIANGLE: begin
        if (u < 16'd16384) begin
          shape_lfo = 16'd16384 + u;
        end else if (u < 16'd49152) begin
          shape_lfo = 16'd49152 - u;
        end else begin
          shape_lfo = u - 16'd49152;
        end
      end
      SHAPE_SQUARE: begin
        shape_lfo = (u < 16'd32768) ? 16'd32768 : 16'd0;
      end
      SHAPE_SLOPED: begin
        if (p32 < EDGE_FALL) begin
          shape_lfo = 16'd32768;
        end else if (!p32[31]) begin
          shape_lfo = (slope_d >= 17'd32768) ? 16'd0 : 16'(17'd32768 - slope_d);
        end else if (p32 < EDGE_RISE) begin
          shape_lfo = 16'd0;
        end else begin
          shape_lfo = slope_d[15:0];
        end
      end
      default: begin
        shape_lfo = 16'd0;
      end
    endcase
  end

  // Branch of the current step.
  always_comb begin
    case (uc.jmp)
      J_ALWAYS:   take_jump = 1'b1;
      J_TWO_CH:   take_jump = !four_ch_q;
      J_NOT_SINE: take_jump = (shape_q != SHAPE_SINE);
      J_LOOP:     take_jump = (cnt_q != POLY_LAST);
      default:    take_jump = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (accept) begin
      pc_d = U_GAIN_L;
    end else if (busy_q && (uc.jmp != J_HOLD)) begin
      pc_d = take_jump ? uc.target : pc_q + 1'b1;
    end
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RESET;
      depth_q   <= DEPTH_RESET;
      shape_q   <= SHAPE_RESET;
      step_q    <= STEP_RESET[PHASE_BITS-1:0];
      four_ch_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN:       gain_q    <= cfg_wdata_i[15:0];
        REG_DEPTH:      depth_q   <= cfg_wdata_i[15:0];
        REG_WAVE_SHAPE: shape_q   <= shape_e'(cfg_wdata_i[1:0]);
        REG_PHASE_STEP: step_q    <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_FOUR_CH:    four_ch_q <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer, phase accumulator and output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= U_GAIN_L;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= '0;
    end else begin
      pc_q <= pc_d;
      if (accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (busy_q && (uc.wr == W_POLY)) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // The phase moves on only when side outputs are produced.
      if (done && four_ch_q) begin
        phase_q <= phase_q + step_q;
      end
    end
  end

  // Datapath: each step registers a new product and stores the previous one.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      xl_q <= in_data_i.left_sample;
      xr_q <= in_data_i.right_sample;
      p_q  <= POLY_SEED;
    end else if (busy_q) begin
      case (uc.wr)
        W_FL:    fl_q  <= rnd_sat(prod_q, 13);
        W_FR:    fr_q  <= rnd_sat(prod_q, 13);
        W_K:     k_q   <= p32[30] ? (KW'(SINE_TABLE_DEPTH) - idx) : idx;
        W_T:     t_q   <= prod_q[31:0];
        W_X:     x_q   <= prod_q[30:0];
        W_XADD:  x_q   <= x_q + 31'(prod_q[65:37]);
        W_X2:    x2_q  <= prod_q[60:30];
        W_POLY:  p_q   <= POLY_COEF[cnt_q] - prod_q[61:30];
        W_SINE:  lfo_q <= sine_lfo;
        W_SHAPE: lfo_q <= shape_lfo;
        W_M:     m_q   <= 32'h4000_0000 - prod_q[31:0];
        W_SL:    sl_q  <= rnd_sat(prod_q, 30);
        W_SR:    sr_q  <= rnd_sat(prod_q, 30);
        default: begin
        end
      endcase
    end
    if (done) begin
      out_q.front_left  <= fl_q;
      out_q.front_right <= fr_q;
      out_q.side_left   <= four_ch_q ? sl_q : '0;
      out_q.side_right  <= four_ch_q ? sr_q : '0;
      out_q.side_valid  <= four_ch_q;
    end
  end

endmodule

@@ bench/tb_tremolo_lfo_gain_stage.sv @@
module tb_tremolo_lfo_gain_stage;
  timeunit 1ns;
  timeprecision 1ps;

  import tlfo_pkg::*;

  // The slowest frame (sine shape) runs the longest microcode path from acceptance
  // to the result register; SETTLE_CYCLES idle cycles leave the block surely at rest.
  localparam int SETTLE_CYCLES = 30;
  // Roughly 800 frames, each with at worst a sender gap, the sine-shape work
  // and several stacked receiver stalls, plus register writes and pauses.
  // This bound is several times that worst case.
  localparam int CYCLE_LIMIT = 400000;

  // Register indexes past the end of the map; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;

  // LFO constants: sloped square edges, half turn of the 32-bit phase, and the
  // size of the quarter-wave sine grid.
  localparam longint unsigned SLOPE_FALL_AT = 64'd2061584302;
  localparam longint unsigned SLOPE_RISE_AT = 64'd4209067950;
  localparam longint unsigned HALF_TURN     = 64'h8000_0000;
  localparam longint unsigned SINE_DEPTH    = 64'd256;

  localparam logic [15:0] UNITY_GAIN = 16'd8192;
  localparam logic [15:0] FULL_DEPTH = 16'd32768;

  // Largest and smallest sample at the port width.
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP    = SAMPLE_BITS'(S_MAX);
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM = SAMPLE_BITS'(S_MIN);

  logic      clk = 1'b0;
  logic      rst_n;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  // Mirror of the block's registers and LFO phase, starting at reset values.
  logic [15:0] cfg_gain  = 16'd5161;
  logic [15:0] cfg_depth = 16'd32768;
  shape_e      cfg_shape = SHAPE_SQUARE;
  logic [31:0] cfg_step  = 32'd178957;
  logic        cfg_four  = 1'b1;
  logic [31:0] lfo_phase = '0;

  // Result words predicted for accepted frames, oldest first.
  out_word_t pending_frames[$];

  int idle_pct = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int settings_applied = 0;
  int mismatches = 0;
  int cycle_count = 0;

  tremolo_lfo_gain_stage DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shift right with rounding to nearest (ties upward), then clamp to the
  // signed sample range.
  function automatic longint round_sat(longint v, int sh);
    longint t;
    t = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (t > S_MAX) begin
      t = S_MAX;
    end else if (t < S_MIN) begin
      t = S_MIN;
    end
    return t;
  endfunction

  // Computes the result word for one stereo frame from the mirrored registers
  // and steps the LFO phase the way the block does.
  function automatic out_word_t tremolo_predict(in_word_t w);
    out_word_t r;
    longint front_l, front_r, side_l, side_r, swing;
    longint unsigned p32, u, q, idx, x, x2, poly, s, lfo, dv;
    front_l = round_sat(longint'(w.left_sample) * longint'(cfg_gain), 13);
    front_r = round_sat(longint'(w.right_sample) * longint'(cfg_gain), 13);
    r = '0;
    r.front_left  = front_l[SAMPLE_BITS-1:0];
    r.front_right = front_r[SAMPLE_BITS-1:0];
    if (cfg_four) begin
      p32 = lfo_phase;
      u = p32 >> 16;
      case (cfg_shape)
        SHAPE_TRIANGLE: begin
          if (u < 16384) lfo = 16384 + u;
          else if (u < 49152) lfo = 49152 - u;
          else lfo = u - 49152;
        end
        SHAPE_SQUARE: begin
          lfo = (u < 32768) ? 64'd32768 : 64'd0;
        end
        SHAPE_SLOPED: begin
          // Flat top, a steep falling ramp just before the half turn, flat
          // bottom, and a steep rising ramp at the end of the turn.
          if (p32 < SLOPE_FALL_AT) begin
            lfo = 32768;
          end else if (p32 < HALF_TURN) begin
            dv = (64'd50 * (p32 - SLOPE_FALL_AT)) >> 17;
            lfo = (dv >= 32768) ? 64'd0 : 64'd32768 - dv;
          end else if (p32 < SLOPE_RISE_AT) begin
            lfo = 0;
          end else begin
            lfo = (64'd50 * (p32 - SLOPE_RISE_AT)) >> 17;
          end
        end
        default: begin
          // Quarter-wave sine: odd quadrants read the grid mirrored, the
          // lower half of the turn is positive, the upper half negative.
          q = p32 >> 30;
          idx = ((p32 & 64'h3FFF_FFFF) * SINE_DEPTH) >> 30;
          if (q[0]) idx = SINE_DEPTH - idx;
          x = (idx << 30) / SINE_DEPTH;
          x2 = (x * x) >> 30;
          poly = 64'd5026995 - ((64'd172272 * x2) >> 30);
          poly = 64'd85569306 - ((poly * x2) >> 30);
          poly = 64'd693598668 - ((poly * x2) >> 30);
          poly = 64'd1686629713 - ((poly * x2) >> 30);
          s = (poly * x) >> 30;
          s = (s + 64'd16384) >> 15;
          if (s > 32768) s = 32768;
          lfo = (q < 2) ? (64'd32768 + s) >> 1 : (64'd32768 - s) >> 1;
        end
      endcase
      swing = longint'(64'd1 << 30) - longint'(longint'(cfg_depth) * lfo);
      side_l = round_sat(front_l * swing, 30);
      side_r = round_sat(front_r * swing, 30);
      r.side_left  = side_l[SAMPLE_BITS-1:0];
      r.side_right = side_r[SAMPLE_BITS-1:0];
      r.side_valid = 1'b1;
      lfo_phase = lfo_phase + cfg_step;
    end
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 5))
      0: return SAMPLE_TOP;
      1: return SAMPLE_BOTTOM;
      2: return SAMPLE_BITS'($urandom_range(0, 4095) - 2048);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic void check_field(string name, logic signed [SAMPLE_BITS-1:0] want,
                                      logic signed [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Writes one register at the next rising edge and leaves the write enable
  // high; the caller lowers it once its last write is done.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN:       cfg_gain = data[15:0];
      REG_DEPTH:      cfg_depth = data[15:0];
      REG_WAVE_SHAPE: cfg_shape = shape_e'(data[1:0]);
      REG_PHASE_STEP: cfg_step = data;
      REG_FOUR_CH:    cfg_four = data[0];
      default: ;
    endcase
  endtask

  // Programs all five registers. Bits above each register's width carry
  // random junk, which the block has to drop.
  task automatic program_regs(logic [15:0] gain, logic [15:0] depth, shape_e shape,
                              logic [31:0] step, logic four);
    write_reg(REG_GAIN, {16'($urandom), gain});
    write_reg(REG_DEPTH, {16'($urandom), depth});
    write_reg(REG_WAVE_SHAPE, {30'($urandom), shape});
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_FOUR_CH, {31'($urandom), four});
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Draws a register setting, leaning on the limits of gain, depth and step.
  task automatic randomize_regs();
    logic [15:0] gain, depth;
    logic [31:0] step;
    case ($urandom_range(0, 5))
      0, 1: gain = 16'($urandom);
      2, 3: gain = 16'($urandom_range(4096, 12288));
      4: gain = 16'hFFFF;
      default: gain = '0;
    endcase
    case ($urandom_range(0, 5))
      0: depth = 16'($urandom);
      1, 2: depth = 16'($urandom_range(0, 32768));
      3: depth = '0;
      4: depth = FULL_DEPTH;
      default: depth = 16'hFFFF;
    endcase
    case ($urandom_range(0, 4))
      0, 1: step = $urandom;
      2: step = $urandom_range(0, 1 << 20);
      3: step = '0;
      default: step = '1;
    endcase
    program_regs(gain, depth, shape_e'($urandom_range(0, 3)), step,
                 $urandom_range(0, 4) != 0);
  endtask

  // Offers one frame, holds it until the block takes it, and queues the
  // predicted result. Valid stays high afterwards so back-to-back frames
  // need no extra edge; a sender gap lowers it first.
  task automatic send_frame(logic signed [SAMPLE_BITS-1:0] left,
                            logic signed [SAMPLE_BITS-1:0] right);
    in_word_t w;
    w.left_sample = left;
    w.right_sample = right;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    pending_frames.push_back(tremolo_predict(w));
    frames_sent++;
  endtask

  // Stops offering frames and waits until every result word has come back,
  // then lets the block run out its latency before anything else happens.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Frames straight after reset check every register's reset value at once.
  task automatic test_reset_values();
    repeat (4) send_frame(random_sample(), random_sample());
    wait_drained();
  endtask

  task automatic test_sample_extremes();
    program_regs(UNITY_GAIN, FULL_DEPTH, SHAPE_TRIANGLE, 32'h1000_0000, 1'b1);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    send_frame(SAMPLE_BOTTOM, SAMPLE_TOP);
    send_frame('0, '1);
    send_frame(24'h555555, 24'hAAAAAA);
    send_frame(24'hAAAAAA, 24'h555555);
    wait_drained();
  endtask

  // Full-scale gain saturates the fronts; zero gain silences everything.
  task automatic test_gain_extremes();
    program_regs(16'hFFFF, FULL_DEPTH, SHAPE_SQUARE, 32'h8000_0000, 1'b1);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    send_frame(24'sh000400, -24'sh000400);
    wait_drained();
    program_regs(16'h0000, FULL_DEPTH, SHAPE_SQUARE, 32'h8000_0000, 1'b1);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    wait_drained();
  endtask

  // With depth near two the modulation factor goes negative while the square is
  // high, and the sides come out inverted there.
  task automatic test_depth_over_one();
    program_regs(UNITY_GAIN, 16'hFFFF, SHAPE_SQUARE, 32'h8000_0000, 1'b1);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    wait_drained();
  endtask

  task automatic test_each_shape();
    for (int sh = SHAPE_SINE; sh <= SHAPE_SLOPED; sh++) begin
      program_regs(UNITY_GAIN, FULL_DEPTH, shape_e'(sh), 32'h5000_0001, 1'b1);
      send_frame(random_sample(), random_sample());
      send_frame(random_sample(), random_sample());
      wait_drained();
    end
  endtask

  // In two-channel mode the sides read zero, are marked invalid, and the
  // phase holds still.
  task automatic test_two_channel();
    program_regs(UNITY_GAIN, FULL_DEPTH, SHAPE_SINE, 32'h1234_5678, 1'b0);
    send_frame(SAMPLE_TOP, SAMPLE_BOTTOM);
    send_frame(random_sample(), random_sample());
    wait_drained();
  endtask

  // Writes past the register map must leave every setting as it was.
  task automatic test_spare_index();
    for (int r = REG_SPARE_LO; r < 2 ** CFG_IDX_W; r++) begin
      write_reg(CFG_IDX_W'(r), '1);
    end
    cfg_we <= 1'b0;
    send_frame(random_sample(), random_sample());
    wait_drained();
  endtask

  // Bulk of the run: a fresh random setting per batch, with each batch
  // picking its own amount of idling, none at all included.
  task automatic test_random_settings(int batches, int per_batch);
    for (int b = 0; b < batches; b++) begin
      case ($urandom_range(0, 3))
        0: idle_pct = 0;
        1: idle_pct = 10;
        2: idle_pct = 30;
        default: idle_pct = 60;
      endcase
      randomize_regs();
      repeat (per_batch) send_frame(random_sample(), random_sample());
      wait_drained();
    end
  endtask

  // The sender stops halfway until the block has returned every word, then
  // resumes on the same setting.
  task automatic test_pause_midstream();
    idle_pct = 30;
    randomize_regs();
    repeat (30) send_frame(random_sample(), random_sample());
    wait_drained();
    repeat (30) send_frame(random_sample(), random_sample());
    wait_drained();
  endtask

  // Last stretch at full rate on both sides.
  task automatic test_full_rate();
    idle_pct = 0;
    randomize_regs();
    repeat (60) send_frame(random_sample(), random_sample());
    wait_drained();
  endtask

  // Receiver back-pressure in random bursts, governed by the same knob.
  always begin
    @(posedge clk);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_frames.size() == 0) begin
        $display("%0t ns: result word arrived with no frame outstanding", $time);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("front_left", want.front_left, out_data.front_left);
        check_field("front_right", want.front_right, out_data.front_right);
        check_field("side_left", want.side_left, out_data.side_left);
        check_field("side_right", want.side_right, out_data.side_right);
        check_field("side_valid", SAMPLE_BITS'(want.side_valid),
                    SAMPLE_BITS'(out_data.side_valid));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding",
               cycle_count, pending_frames.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_sample_extremes();
    test_gain_extremes();
    test_depth_over_one();
    test_each_shape();
    test_two_channel();
    test_spare_index();
    test_random_settings(13, 50);
    test_pause_midstream();
    test_full_rate();

    $display("Sent %0d stereo frames under %0d register settings: all LFO shapes,",
             frames_sent, settings_applied);
    $display("both channel modes, gain and depth limits; %0d words checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
